/* sv/c2zp_pkg.sv */
// Shared types and constants for the zero-padded 2D convolution point query core.
package c2zp_pkg;

	// Field widths fixed by the interface
	localparam int POS_W      = 6;
	localparam int VAL_W      = 16;
	localparam int PROD_W     = 32;
	localparam int OUT_W      = 36;
	localparam int MSZ_W      = 7;
	localparam int KSZ_W      = 3;
	localparam int SUM_W      = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Request codes
	typedef enum logic [1:0] {
		REQ_KERN  = 2'd0,
		REQ_MAT   = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAT_ROWS  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAT_COLS  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERN_ROWS = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERN_COLS = 4'd3;

	// Configuration reset values
	localparam logic [MSZ_W-1:0] MAT_ROWS_RST  = 7'd64;
	localparam logic [MSZ_W-1:0] MAT_COLS_RST  = 7'd64;
	localparam logic [KSZ_W-1:0] KERN_ROWS_RST = 3'd3;
	localparam logic [KSZ_W-1:0] KERN_COLS_RST = 3'd3;

	typedef struct packed {
		logic [MSZ_W-1:0] mat_rows;
		logic [MSZ_W-1:0] mat_cols;
		logic [KSZ_W-1:0] kern_rows;
		logic [KSZ_W-1:0] kern_cols;
	} cfg_t;

	typedef struct packed {
		req_t                    kind;
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	// Head of the command queue as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

/* sv/c2zp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c2zp_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/c2zp_front.sv */
// Front end: accepts requests, drops out-of-range writes and unused codes, queues the rest.
module c2zp_front #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int KMAX     = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [1:0]                   req_type,
	input  logic [c2zp_pkg::POS_W-1:0]   pos_row,
	input  logic [c2zp_pkg::POS_W-1:0]   pos_col,
	input  logic signed [c2zp_pkg::VAL_W-1:0] value,
	input  c2zp_pkg::cfg_t               cfg,
	output logic                         busy,
	output c2zp_pkg::head_t              head,
	input  logic                         pop
);

	import c2zp_pkg::*;

	cmd_t              fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              kern_ok;
	logic              mat_ok;
	logic              keep;
	logic              push;
	cmd_t              cmd_in;

	// Classify the incoming request
	always_comb begin
		kern_ok = (pos_row < cfg.kern_rows) && (pos_row < KMAX) &&
		          (pos_col < cfg.kern_cols) && (pos_col < KMAX);
		mat_ok  = (pos_row < cfg.mat_rows) && (pos_row < MAX_ROWS) &&
		          (pos_col < cfg.mat_cols) && (pos_col < MAX_COLS);
		case (req_type)
			REQ_KERN:  keep = kern_ok;
			REQ_MAT:   keep = mat_ok;
			REQ_QUERY: keep = 1'b1;
			default:   keep = 1'b0;
		endcase
		cmd_in.kind  = req_t'(req_type);
		cmd_in.row   = pos_row;
		cmd_in.col   = pos_col;
		cmd_in.value = value;
	end

	assign busy = (count_q == QCNT_W'(QDEPTH));
	assign push = start && !busy && keep;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head.valid = (count_q != '0);
	assign head.cmd   = fifo_q[rd_ptr_q];

endmodule

/* sv/c2zp_back.sv */
// Back end: store writes and a tap sequencer driving one shared multiply-accumulate.
module c2zp_back #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int KMAX     = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  c2zp_pkg::cfg_t                      cfg,
	input  c2zp_pkg::head_t                     head,
	output logic                                pop,
	output logic                                done,
	output logic signed [c2zp_pkg::OUT_W-1:0]   conv_value
);

	import c2zp_pkg::*;

	localparam int MDEPTH = MAX_ROWS * MAX_COLS;
	localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int MFW    = MAW + 8;
	localparam int KDEPTH = KMAX * KMAX;
	localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
	localparam int KFW    = KAW + 4;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                  state_q;
	logic [POS_W-1:0]        row_q;
	logic [POS_W-1:0]        col_q;
	logic [KSZ_W-1:0]        i_q;
	logic [KSZ_W-1:0]        j_q;

	logic [KSZ_W-1:0]        kr_eff;
	logic [KSZ_W-1:0]        kc_eff;
	logic                    empty;
	logic                    row_end;
	logic                    col_end;
	logic                    tap_last;
	logic [SUM_W-1:0]        tap_r;
	logic [SUM_W-1:0]        tap_c;
	logic                    tap_in;
	logic                    run;

	logic [MFW-1:0]          m_raddr_full;
	logic [MFW-1:0]          m_waddr_full;
	logic [KFW-1:0]          k_raddr_full;
	logic [KFW-1:0]          k_waddr_full;
	logic                    m_we;
	logic                    k_we;
	logic [VAL_W-1:0]        m_rdata;
	logic [VAL_W-1:0]        k_rdata;
	logic signed [PROD_W-1:0] prod;

	logic                    act_s1;
	logic                    last_s1;
	logic                    hit_s1;
	logic                    act_s2;
	logic                    last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [OUT_W-1:0] acc_q;
	logic signed [OUT_W-1:0] sum;
	logic signed [OUT_W-1:0] conv_q;
	logic                    done_q;

	// Effective kernel size and tap position
	always_comb begin
		kr_eff   = (cfg.kern_rows > KSZ_W'(KMAX)) ? KSZ_W'(KMAX) : cfg.kern_rows;
		kc_eff   = (cfg.kern_cols > KSZ_W'(KMAX)) ? KSZ_W'(KMAX) : cfg.kern_cols;
		empty    = (kr_eff == '0) || (kc_eff == '0);
		row_end  = (i_q == kr_eff - KSZ_W'(1));
		col_end  = (j_q == kc_eff - KSZ_W'(1));
		tap_last = empty || (row_end && col_end);
		tap_r    = SUM_W'(row_q) + SUM_W'(i_q);
		tap_c    = SUM_W'(col_q) + SUM_W'(j_q);
		tap_in   = (tap_r < cfg.mat_rows) && (tap_r < MAX_ROWS) &&
		           (tap_c < cfg.mat_cols) && (tap_c < MAX_COLS);
		run      = (state_q == ST_RUN);
	end

	// Store addressing
	always_comb begin
		m_raddr_full = MFW'(tap_r) * MFW'(MAX_COLS) + MFW'(tap_c);
		m_waddr_full = MFW'(head.cmd.row) * MFW'(MAX_COLS) + MFW'(head.cmd.col);
		k_raddr_full = KFW'(i_q) * KFW'(KMAX) + KFW'(j_q);
		k_waddr_full = KFW'(head.cmd.row) * KFW'(KMAX) + KFW'(head.cmd.col);
	end

	// Dispatch from the queue head
	assign pop  = (state_q == ST_IDLE) && head.valid;
	assign m_we = pop && (head.cmd.kind == REQ_MAT);
	assign k_we = pop && (head.cmd.kind == REQ_KERN);

	c2zp_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MDEPTH)
	) u_mat_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr_full[MAW-1:0]),
		.wdata (head.cmd.value),
		.raddr (m_raddr_full[MAW-1:0]),
		.rdata (m_rdata)
	);

	c2zp_ram #(
		.WIDTH (VAL_W),
		.DEPTH (KDEPTH)
	) u_kern_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr_full[KAW-1:0]),
		.wdata (head.cmd.value),
		.raddr (k_raddr_full[KAW-1:0]),
		.rdata (k_rdata)
	);

	// Tap sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && (head.cmd.kind == REQ_QUERY)) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (tap_last) begin
						state_q <= ST_IDLE;
					end else if (col_end) begin
						j_q <= '0;
						i_q <= i_q + KSZ_W'(1);
					end else begin
						j_q <= j_q + KSZ_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query position latch
	always_ff @(posedge clk) begin
		if (pop && (head.cmd.kind == REQ_QUERY)) begin
			row_q <= head.cmd.row;
			col_q <= head.cmd.col;
		end
	end

	assign prod = $signed(m_rdata) * $signed(k_rdata);
	assign sum  = acc_q + OUT_W'(prod_s2);

	// MAC pipeline control: read, multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1  <= 1'b0;
			last_s1 <= 1'b0;
			hit_s1  <= 1'b0;
			act_s2  <= 1'b0;
			last_s2 <= 1'b0;
			acc_q   <= '0;
			done_q  <= 1'b0;
			conv_q  <= '0;
		end else begin
			act_s1  <= run;
			last_s1 <= run && tap_last;
			hit_s1  <= run && !empty && tap_in;
			act_s2  <= act_s1;
			last_s2 <= last_s1;
			done_q  <= act_s2 && last_s2;
			if (act_s2) begin
				if (last_s2) begin
					conv_q <= sum;
					acc_q  <= '0;
				end else begin
					acc_q <= sum;
				end
			end
		end
	end

	// Product register; padded taps contribute zero
	always_ff @(posedge clk) begin
		prod_s2 <= hit_s1 ? prod : '0;
	end

	assign done       = done_q;
	assign conv_value = conv_q;

endmodule

/* sv/conv2d_zero_pad_point_core.sv */
// Top level of the zero-padded 2D convolution point query core.
// A request is taken when start is high and busy is low; busy rises only when the
// two-entry command queue between the front and back ends is full. A kernel or
// matrix write is performed as it is popped from the queue head; a query holds
// the back end while it steps through kern_rows*kern_cols taps (each size capped
// at KMAX, at least one step) on the single shared multiply-accumulate, which
// reads one matrix and one kernel tap per cycle from their RAMs. Its result is
// registered after the s1 and s2 stages and appears on conv_value with done high
// for exactly one cycle; it cannot be held off by the receiver. Results come in
// request order. Both stores are undefined until written and need no clearing
// after reset. Configuration writes are never stalled.
module conv2d_zero_pad_point_core #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int KMAX     = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            req_type,
	input  logic [c2zp_pkg::POS_W-1:0]            pos_row,
	input  logic [c2zp_pkg::POS_W-1:0]            pos_col,
	input  logic signed [c2zp_pkg::VAL_W-1:0]     value,
	output logic                                  done,
	output logic signed [c2zp_pkg::OUT_W-1:0]     conv_value,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [c2zp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [c2zp_pkg::CFG_DATA_W-1:0]       cfg_data
);

	import c2zp_pkg::*;

	cfg_t  cfg_q;
	head_t head;
	logic  pop;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mat_rows  <= MAT_ROWS_RST;
			cfg_q.mat_cols  <= MAT_COLS_RST;
			cfg_q.kern_rows <= KERN_ROWS_RST;
			cfg_q.kern_cols <= KERN_COLS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAT_ROWS:  cfg_q.mat_rows  <= cfg_data[MSZ_W-1:0];
				REG_MAT_COLS:  cfg_q.mat_cols  <= cfg_data[MSZ_W-1:0];
				REG_KERN_ROWS: cfg_q.kern_rows <= cfg_data[KSZ_W-1:0];
				REG_KERN_COLS: cfg_q.kern_cols <= cfg_data[KSZ_W-1:0];
				default: ;
			endcase
		end
	end

	c2zp_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.KMAX     (KMAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.pos_row  (pos_row),
		.pos_col  (pos_col),
		.value    (value),
		.cfg      (cfg_q),
		.busy     (busy),
		.head     (head),
		.pop      (pop)
	);

	c2zp_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.KMAX     (KMAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.conv_value (conv_value)
	);

endmodule

/* sv/c2zp_checker.sv */
// Port-level checks for the convolution point query core, bound to the top level.
module c2zp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [c2zp_pkg::OUT_W-1:0]        conv_value,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);

	// Every query is dispatched from the idle state, so results never come back to back
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done high in two consecutive cycles");

	// Result data only changes together with its strobe
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(conv_value))
		else $error("conv_value changed without done");

	// The queue fills only through an accepted transaction
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	// Configuration transactions are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind conv2d_zero_pad_point_core c2zp_checker u_c2zp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.conv_value (conv_value),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);

/* bench/conv2d_zero_pad_point_sb_pkg.sv */
// Scoreboard for the zero-padded 2D convolution point query core: shadow stores and sums due.
package conv2d_zero_pad_point_sb_pkg;

	import c2zp_pkg::*;

	class conv_scoreboard;
		localparam int MAXR = 64;
		localparam int MAXC = 64;
		localparam int KM   = 5;

		logic signed [VAL_W-1:0] mat_mem [MAXR][MAXC];
		logic signed [VAL_W-1:0] kern_mem [KM][KM];
		cfg_t                    regs;
		logic [OUT_W-1:0]        sums_due [$];
		int                      fail_count;

		function new();
			regs.mat_rows  = MAT_ROWS_RST;
			regs.mat_cols  = MAT_COLS_RST;
			regs.kern_rows = KERN_ROWS_RST;
			regs.kern_cols = KERN_COLS_RST;
			foreach (mat_mem[r, c]) mat_mem[r][c] = '0;
			foreach (kern_mem[r, c]) kern_mem[r][c] = '0;
			fail_count = 0;
		endfunction

		// Sizes above the store bound act as the bound
		function int bounded(int v, int lim);
			return (v > lim) ? lim : v;
		endfunction

		function void sizes(output int mr, output int mc, output int kr, output int kc);
			mr = bounded(int'(regs.mat_rows), MAXR);
			mc = bounded(int'(regs.mat_cols), MAXC);
			kr = bounded(int'(regs.kern_rows), KM);
			kc = bounded(int'(regs.kern_cols), KM);
		endfunction

		// Accepted register write transaction
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MAT_ROWS:  regs.mat_rows  = data[MSZ_W-1:0];
				REG_MAT_COLS:  regs.mat_cols  = data[MSZ_W-1:0];
				REG_KERN_ROWS: regs.kern_rows = data[KSZ_W-1:0];
				REG_KERN_COLS: regs.kern_cols = data[KSZ_W-1:0];
				default: ;
			endcase
		endfunction

		// Accepted request transaction: update the stores or queue the sum
		function void note_request(req_t kind, logic [POS_W-1:0] row, logic [POS_W-1:0] col,
				logic signed [VAL_W-1:0] val);
			int     mr, mc, kr, kc;
			int     i, j, r, c;
			longint acc;
			sizes(mr, mc, kr, kc);
			case (kind)
				REQ_KERN: begin
					if (row < kr && col < kc) kern_mem[row][col] = val;
				end
				REQ_MAT: begin
					if (row < mr && col < mc) mat_mem[row][col] = val;
				end
				REQ_QUERY: begin
					acc = 0;
					for (i = 0; i < kr; i++) begin
						for (j = 0; j < kc; j++) begin
							r = int'(row) + i;
							c = int'(col) + j;
							// zero padding outside the matrix
							if (r < mr && c < mc)
								acc += longint'(mat_mem[r][c]) * longint'(kern_mem[i][j]);
						end
					end
					sums_due.push_back(acc[OUT_W-1:0]);
				end
				default: ;
			endcase
		endfunction

		// Result transaction against the oldest sum due
		function void check_result(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			if (sums_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected conv_value %0d with no query pending", $signed(got));
				return;
			end
			want = sums_due.pop_front();
			if (got !== want) begin
				fail_count++;
				if (fail_count <= 10)
					$display("conv_value mismatch: expected %0d actual %0d",
						$signed(want), $signed(got));
			end
		endfunction

		function int pending();
			return sums_due.size();
		endfunction
	endclass

endpackage

/* bench/conv2d_zero_pad_point_core_tb.sv */
// Testbench for the zero-padded 2D convolution point query core.
module conv2d_zero_pad_point_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import c2zp_pkg::*;
	import conv2d_zero_pad_point_sb_pkg::*;

	localparam int LIMIT = 1000000;

	logic                    clk;
	logic                    arst_n     = 1'b0;
	logic                    start      = 1'b0;
	logic                    busy;
	logic [1:0]              req_type   = '0;
	logic [POS_W-1:0]        pos_row    = '0;
	logic [POS_W-1:0]        pos_col    = '0;
	logic signed [VAL_W-1:0] value      = '0;
	logic                    done;
	logic signed [OUT_W-1:0] conv_value;
	logic                    cfg_valid  = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index  = '0;
	logic [CFG_DATA_W-1:0]   cfg_data   = '0;

	conv_scoreboard sb;

	// Entries written so far; queries never read anything else
	bit kern_done [5][5];
	bit mat_done [64][64];
	int eff_mr, eff_mc, eff_kr, eff_kc;
	int win_r, win_c;
	int burst_left = 4;
	int taken_items;
	int cycle_count = 0;

	conv2d_zero_pad_point_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.pos_row    (pos_row),
		.pos_col    (pos_col),
		.value      (value),
		.done       (done),
		.conv_value (conv_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Monitor: request, register and result transactions
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_request(req_t'(req_type), pos_row, pos_col, value);
		if (arst_n && cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
		if (arst_n && done)
			sb.check_result(conv_value);
	end

	// One request transaction, then burst/gap pacing
	task automatic issue(req_t kind, int row, int col, logic [VAL_W-1:0] val);
		start    <= 1'b1;
		req_type <= kind;
		pos_row  <= row[POS_W-1:0];
		pos_col  <= col[POS_W-1:0];
		value    <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (kind == REQ_KERN && row < eff_kr && col < eff_kc) begin
			kern_done[row][col] = 1'b1;
			taken_items++;
		end else if (kind == REQ_MAT && row < eff_mr && col < eff_mc) begin
			mat_done[row][col] = 1'b1;
			taken_items++;
		end else if (kind == REQ_QUERY) begin
			taken_items++;
		end
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
	endtask

	// Fill whatever the query would read, then issue it
	task automatic query_at(int row, int col);
		int i, j, r, c;
		for (i = 0; i < eff_kr; i++)
			for (j = 0; j < eff_kc; j++)
				if (!kern_done[i][j]) issue(REQ_KERN, i, j, VAL_W'($urandom));
		for (i = 0; i < eff_kr; i++) begin
			for (j = 0; j < eff_kc; j++) begin
				r = row + i;
				c = col + j;
				if (r < eff_mr && c < eff_mc && !mat_done[r][c])
					issue(REQ_MAT, r, c, VAL_W'($urandom));
			end
		end
		issue(REQ_QUERY, row, col, VAL_W'($urandom));
	endtask

	// Hold requests until every pending sum has come back and the queue is not full
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// All four sizes plus one write to an unused index
	task automatic set_sizes(logic [7:0] mr, logic [7:0] mc, logic [7:0] kr, logic [7:0] kc);
		write_reg(REG_MAT_ROWS, mr);
		write_reg(REG_MAT_COLS, mc);
		write_reg(REG_KERN_ROWS, kr);
		write_reg(REG_KERN_COLS, kc);
		write_reg(CFG_IDX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
		sb.sizes(eff_mr, eff_mc, eff_kr, eff_kc);
	endtask

	// Mostly inside a small window so stores fill quickly, some at the far edge
	function automatic int pick_coord(int win, int span);
		int k;
		k = $urandom_range(0, 9);
		if (k < 7) return (win + $urandom_range(0, 7) > 63) ? 63 : win + $urandom_range(0, 7);
		if (k < 9) return $urandom_range((span > 5) ? span - 5 : 0, 63);
		return $urandom_range(0, 63);
	endfunction

	task automatic run_phase(logic [7:0] mr, logic [7:0] mc, logic [7:0] kr, logic [7:0] kc,
			int target);
		int sel, row, col;
		drain();
		set_sizes(mr, mc, kr, kc);
		win_r = $urandom_range(0, (eff_mr > 8) ? eff_mr - 8 : 0);
		win_c = $urandom_range(0, (eff_mc > 8) ? eff_mc - 8 : 0);
		taken_items = 0;
		while (taken_items < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 18) begin
				if (eff_kr > 0 && eff_kc > 0 && $urandom_range(0, 4) != 0) begin
					row = $urandom_range(0, eff_kr - 1);
					col = $urandom_range(0, eff_kc - 1);
				end else begin
					row = $urandom_range(0, 63);
					col = $urandom_range(0, 63);
				end
				issue(REQ_KERN, row, col, VAL_W'($urandom));
			end else if (sel < 48) begin
				issue(REQ_MAT, pick_coord(win_r, eff_mr), pick_coord(win_c, eff_mc),
					VAL_W'($urandom));
			end else if (sel < 93) begin
				query_at(pick_coord(win_r, eff_mr), pick_coord(win_c, eff_mc));
			end else if (sel < 97) begin
				issue(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
					VAL_W'($urandom));
			end else begin
				// sender pause until nothing is outstanding
				start <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes of value and position, padding, unused request
		set_sizes(8'd64, 8'd64, 8'd2, 8'd2);
		issue(REQ_KERN, 0, 0, 16'h8000);
		issue(REQ_KERN, 0, 1, 16'h8000);
		issue(REQ_KERN, 1, 0, 16'h8000);
		issue(REQ_KERN, 1, 1, 16'h8000);
		issue(REQ_KERN, 2, 2, 16'h1234);
		issue(REQ_KERN, 63, 63, 16'hFFFF);
		issue(REQ_MAT, 62, 62, 16'h8000);
		issue(REQ_MAT, 62, 63, 16'h8000);
		issue(REQ_MAT, 63, 62, 16'h8000);
		issue(REQ_MAT, 63, 63, 16'h8000);
		query_at(62, 62);
		query_at(63, 63);
		issue(REQ_MAT, 0, 0, 16'h7FFF);
		issue(REQ_MAT, 0, 1, 16'h7FFF);
		issue(REQ_MAT, 1, 0, 16'h7FFF);
		issue(REQ_MAT, 1, 1, 16'h7FFF);
		query_at(0, 0);
		issue(REQ_NONE, 63, 63, 16'hFFFF);
		query_at(63, 0);

		// Random phases: full size, minimum, zero sizes, oversized, then mixed
		run_phase(8'd64, 8'd64, 8'd5, 8'd5, 220);
		run_phase(8'd1, 8'd1, 8'd1, 8'd1, 80);
		run_phase(8'h80, 8'h80, 8'd3, 8'd3, 60);
		run_phase(8'd8, 8'd8, 8'hF8, 8'hF8, 60);
		run_phase(8'hFF, 8'hFF, 8'hFF, 8'hFF, 200);
		run_phase(8'd12, 8'd6, 8'd4, 8'd2, 150);
		repeat (4) begin
			run_phase(8'(($urandom_range(0, 3) == 0) ? $urandom_range(33, 64)
					: $urandom_range(1, 16)),
				8'(($urandom_range(0, 3) == 0) ? $urandom_range(33, 64)
					: $urandom_range(1, 16)),
				8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)), 125);
		end

		drain();
		repeat (30) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
